/* design/gamma_correct_channel_scaler_macros.svh */
// assertion helpers for the channel scaler, clocked on i_clk, off during reset
`ifndef GAMMA_CORRECT_CHANNEL_SCALER_MACROS_SVH
`define GAMMA_CORRECT_CHANNEL_SCALER_MACROS_SVH

`ifndef ASSERT_OFF

// consequent checked in the same cycle as the antecedent
`define GCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcs check failed");

// consequent checked in the cycle after the antecedent
`define GCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcs next-cycle check failed");

// consequent checked once the delay given by dly has passed after the antecedent
`define GCS_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("gcs delayed check failed");

`else

`define GCS_ASSERT_SAME(lbl, ante, cons)
`define GCS_ASSERT_NEXT(lbl, ante, cons)
`define GCS_ASSERT_DELAY(lbl, ante, dly, cons)

`endif

`endif

/* design/gcs_pkg.sv */
package gcs_pkg;

    localparam int DEF_LINEAR_BITS       = 16;
    localparam int DEF_ENCODE_INDEX_BITS = 12;

    localparam int BYTE_W      = 8;
    localparam int BYTE_CODES  = 256;
    localparam int BYTE_MAX    = 255;
    localparam int FACTOR_W    = 17;
    localparam int FACTOR_FRAC = 16;
    localparam logic [FACTOR_W-1:0] UNIT_FACTOR = 17'h10000;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_FACTOR_RED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FACTOR_GREEN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FACTOR_BLUE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FACTOR_ALPHA = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_MODE   = 3'd4;

    localparam logic MODE_BASE     = 1'b0;
    localparam logic MODE_MATERIAL = 1'b1;

    // gamma 2.2 taken as 11/5
    localparam int GAMMA_NUM = 11;
    localparam int GAMMA_DEN = 5;
    localparam int WIDE_W    = 256;

    typedef struct packed {
        logic [BYTE_W-1:0] in_red;
        logic [BYTE_W-1:0] in_green;
        logic [BYTE_W-1:0] in_blue;
        logic [BYTE_W-1:0] in_alpha;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_red;
        logic [BYTE_W-1:0] out_green;
        logic [BYTE_W-1:0] out_blue;
        logic [BYTE_W-1:0] out_alpha;
    } t_res;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor_red;
        logic [FACTOR_W-1:0] factor_green;
        logic [FACTOR_W-1:0] factor_blue;
        logic [FACTOR_W-1:0] factor_alpha;
        logic                scale_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{UNIT_FACTOR, UNIT_FACTOR, UNIT_FACTOR, UNIT_FACTOR,
                                   MODE_BASE};

    // elaboration-time helpers for the curve tables, exact integer compares

    function automatic logic [WIDE_W-1:0] wide_mul_pow(input logic [WIDE_W-1:0] a,
                                                       input logic [31:0] base,
                                                       input int count);
        logic [WIDE_W-1:0] acc;
        acc = a;
        for (int n = 0; n < count; n++) begin
            acc = acc * WIDE_W'(base);
        end
        return acc;
    endfunction

    // round(full * (x/255)^(11/5)): largest m with (2m-1)^5 * 255^11 <= x^11 * (2 full)^5
    function automatic logic [31:0] decode_entry(input logic [BYTE_W-1:0] x,
                                                 input int lin_bits);
        logic [31:0]       full;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [31:0]       mid;
        logic [WIDE_W-1:0] rhs;
        logic [WIDE_W-1:0] lhs;
        full = (32'd1 << lin_bits) - 32'd1;
        rhs  = wide_mul_pow(wide_mul_pow(WIDE_W'(1), 32'(x), GAMMA_NUM),
                            32'd2 * full, GAMMA_DEN);
        lo   = '0;
        hi   = full;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 32'd1) >> 1);
            lhs = wide_mul_pow(wide_mul_pow(WIDE_W'(1), 32'd2 * mid - 32'd1, GAMMA_DEN),
                               32'(BYTE_MAX), GAMMA_NUM);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 32'd1;
            end
        end
        return lo;
    endfunction

    // smallest index i with code^11 * D^5 <= i^5 * 255^11, D = 2^idx_bits - 1
    function automatic logic [31:0] encode_threshold(input int code, input int idx_bits);
        logic [31:0]       denom;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [31:0]       mid;
        logic [WIDE_W-1:0] lhs;
        logic [WIDE_W-1:0] rhs;
        denom = (32'd1 << idx_bits) - 32'd1;
        lhs   = wide_mul_pow(wide_mul_pow(WIDE_W'(1), 32'(code), GAMMA_NUM), denom, GAMMA_DEN);
        lo    = '0;
        hi    = denom;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            rhs = wide_mul_pow(wide_mul_pow(WIDE_W'(1), mid, GAMMA_DEN),
                               32'(BYTE_MAX), GAMMA_NUM);
            if (rhs >= lhs) begin
                hi = mid;
            end else begin
                lo = mid + 32'd1;
            end
        end
        return lo;
    endfunction

endpackage

/* design/gcs_ram.sv */
module gcs_ram
    import gcs_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = 1 << DEF_ENCODE_INDEX_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/gcs_fill.sv */
module gcs_fill
    import gcs_pkg::*;
#(
    parameter int ENCODE_INDEX_BITS = DEF_ENCODE_INDEX_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    output logic                         o_we,
    output logic [ENCODE_INDEX_BITS-1:0] o_addr,
    output logic [BYTE_W-1:0]            o_data,
    output logic                         o_done
);

    // first index that reaches each output code
    logic [ENCODE_INDEX_BITS-1:0] thr_rom [BYTE_CODES];

    for (genvar g = 0; g < BYTE_CODES; g++) begin : g_thr
        assign thr_rom[g] = ENCODE_INDEX_BITS'(encode_threshold(g, ENCODE_INDEX_BITS));
    end

    logic [ENCODE_INDEX_BITS-1:0] r_idx;
    logic [ENCODE_INDEX_BITS-1:0] n_idx;
    logic [BYTE_W-1:0]            r_code;
    logic [BYTE_W-1:0]            n_code;
    logic                         r_done;
    logic                         n_done;
    logic [BYTE_W-1:0]            code_up;
    logic                         step;

    assign code_up = r_code + BYTE_W'(1);
    // bump the code while the next threshold is already reached, else write
    assign step    = (r_code != '1) && (thr_rom[code_up] <= r_idx);

    always_comb begin
        n_idx  = r_idx;
        n_code = r_code;
        n_done = r_done;
        if (!r_done) begin
            if (step) begin
                n_code = code_up;
            end else if (r_idx == '1) begin
                n_done = 1'b1;
            end else begin
                n_idx = r_idx + ENCODE_INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_code <= '0;
            r_done <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_code <= n_code;
            r_done <= n_done;
        end
    end

    assign o_we   = !r_done && !step;
    assign o_addr = r_idx;
    assign o_data = r_code;
    assign o_done = r_done;

endmodule

/* design/gcs_lane.sv */
module gcs_lane
    import gcs_pkg::*;
#(
    parameter int LINEAR_BITS       = DEF_LINEAR_BITS,
    parameter int ENCODE_INDEX_BITS = DEF_ENCODE_INDEX_BITS
) (
    input  logic                         i_clk,
    input  logic [BYTE_W-1:0]            i_byte,
    input  logic [FACTOR_W-1:0]          i_factor,
    input  logic                         i_fill_we,
    input  logic [ENCODE_INDEX_BITS-1:0] i_fill_addr,
    input  logic [BYTE_W-1:0]            i_fill_data,
    output logic [BYTE_W-1:0]            o_enc
);

    localparam int PROD_W = LINEAR_BITS + FACTOR_W;

    // gamma 2.2 encoded byte to linear fraction
    logic [LINEAR_BITS-1:0] dec_rom [BYTE_CODES];

    for (genvar g = 0; g < BYTE_CODES; g++) begin : g_dec
        assign dec_rom[g] = LINEAR_BITS'(decode_entry(BYTE_W'(g), LINEAR_BITS));
    end

    logic [LINEAR_BITS-1:0]       n_lin;
    logic [LINEAR_BITS-1:0]       r_lin;
    logic [PROD_W-1:0]            prod;
    logic [LINEAR_BITS:0]         scaled;
    logic [LINEAR_BITS-1:0]       lin_sat;
    logic [ENCODE_INDEX_BITS-1:0] n_idx;
    logic [ENCODE_INDEX_BITS-1:0] r_idx;

    assign n_lin   = dec_rom[i_byte];
    assign prod    = PROD_W'(r_lin) * PROD_W'(i_factor);
    assign scaled  = prod[PROD_W-1:FACTOR_FRAC];
    assign lin_sat = scaled[LINEAR_BITS] ? '1 : scaled[LINEAR_BITS-1:0];

    if (LINEAR_BITS >= ENCODE_INDEX_BITS) begin : g_idx_down
        assign n_idx = lin_sat[LINEAR_BITS-1 -: ENCODE_INDEX_BITS];
    end else begin : g_idx_up
        assign n_idx = {lin_sat, {(ENCODE_INDEX_BITS - LINEAR_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_lin <= n_lin;
        r_idx <= n_idx;
    end

    gcs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (1 << ENCODE_INDEX_BITS)
    ) u_enc_ram (
        .i_clk   (i_clk),
        .i_we    (i_fill_we),
        .i_waddr (i_fill_addr),
        .i_wdata (i_fill_data),
        .i_raddr (r_idx),
        .o_rdata (o_enc)
    );

endmodule

/* design/gcs_cfg.sv */
module gcs_cfg
    import gcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_FACTOR_RED:   n_cfg.factor_red   = pwdata[FACTOR_W-1:0];
                REG_FACTOR_GREEN: n_cfg.factor_green = pwdata[FACTOR_W-1:0];
                REG_FACTOR_BLUE:  n_cfg.factor_blue  = pwdata[FACTOR_W-1:0];
                REG_FACTOR_ALPHA: n_cfg.factor_alpha = pwdata[FACTOR_W-1:0];
                REG_SCALE_MODE:   n_cfg.scale_mode   = pwdata[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FACTOR_RED:   prdata = APB_DATA_W'(r_cfg.factor_red);
            REG_FACTOR_GREEN: prdata = APB_DATA_W'(r_cfg.factor_green);
            REG_FACTOR_BLUE:  prdata = APB_DATA_W'(r_cfg.factor_blue);
            REG_FACTOR_ALPHA: prdata = APB_DATA_W'(r_cfg.factor_alpha);
            REG_SCALE_MODE:   prdata = APB_DATA_W'(r_cfg.scale_mode);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* design/gamma_correct_channel_scaler.sv */
// gamma-correct rgba8 channel scaler: takes one pixel per clock while busy is low and returns
// exactly one scaled pixel per request, on o_res with o_done high for a single cycle;
// there is no backpressure, so the receiver must take every result in the cycle it appears.
// colour channels are decoded through a gamma 2.2 curve to LINEAR_BITS of linear light,
// multiplied by their unsigned 1.16 factor (saturating), and re-encoded through a table
// indexed by the top ENCODE_INDEX_BITS bits; base mode scales r, g, b and alpha (linear,
// truncated), material mode scales only g and b, and unit factors pass the pixel untouched.
// the encode curve lives in one synchronous ram per colour lane, one read per lane per
// cycle, which is what sets the rate of one pixel per clock. after reset the three rams are
// loaded together by a sweep that writes every encode table index in ascending order;
// busy stays high for that whole sweep and start is ignored, while the apb registers can be
// written at any time. factors should only be changed with no request in flight.
`include "gamma_correct_channel_scaler_macros.svh"

module gamma_correct_channel_scaler
    import gcs_pkg::*;
#(
    parameter int LINEAR_BITS       = DEF_LINEAR_BITS,
    parameter int ENCODE_INDEX_BITS = DEF_ENCODE_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // request side
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,

    // result side, no stall
    output logic                  o_done,
    output t_res                  o_res,

    // apb register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // request edge to result strobe
    localparam int LATENCY  = 4;
    localparam int APROD_W  = BYTE_W + FACTOR_W;
    localparam int VLD_W    = LATENCY - 1;

    t_cfg                         cfg;
    logic                         fill_we;
    logic [ENCODE_INDEX_BITS-1:0] fill_addr;
    logic [BYTE_W-1:0]            fill_data;
    logic                         fill_done;
    logic                         accept;

    logic [BYTE_W-1:0]            enc_red;
    logic [BYTE_W-1:0]            enc_green;
    logic [BYTE_W-1:0]            enc_blue;

    // pipeline control
    logic [VLD_W-1:0]             r_vld;
    logic                         r_done;

    // raw pixel carried alongside the lanes
    t_req                         r_p1;
    t_req                         r_p2;
    t_req                         r_p3;

    // alpha path
    logic [APROD_W-1:0]           alpha_prod;
    logic [BYTE_W:0]              alpha_shift;
    logic [BYTE_W-1:0]            n_sa;
    logic [BYTE_W-1:0]            r_sa2;
    logic [BYTE_W-1:0]            r_sa3;

    // output register
    t_res                         n_res;
    t_res                         r_res;
    logic                         n_pass;
    logic                         r_pass;

    // ---------------------------------------------------------------------
    // registers and encode table loader
    // ---------------------------------------------------------------------
    gcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gcs_fill #(
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_we    (fill_we),
        .o_addr  (fill_addr),
        .o_data  (fill_data),
        .o_done  (fill_done)
    );

    // the block only stalls while the encode rams are being loaded
    assign busy   = !fill_done;
    assign accept = start && !busy;

    // ---------------------------------------------------------------------
    // colour lanes: decode on the request cycle, scale, then ram lookup
    // ---------------------------------------------------------------------
    gcs_lane #(
        .LINEAR_BITS       (LINEAR_BITS),
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_lane_red (
        .i_clk       (i_clk),
        .i_byte      (i_req.in_red),
        .i_factor    (cfg.factor_red),
        .i_fill_we   (fill_we),
        .i_fill_addr (fill_addr),
        .i_fill_data (fill_data),
        .o_enc       (enc_red)
    );

    gcs_lane #(
        .LINEAR_BITS       (LINEAR_BITS),
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_lane_green (
        .i_clk       (i_clk),
        .i_byte      (i_req.in_green),
        .i_factor    (cfg.factor_green),
        .i_fill_we   (fill_we),
        .i_fill_addr (fill_addr),
        .i_fill_data (fill_data),
        .o_enc       (enc_green)
    );

    gcs_lane #(
        .LINEAR_BITS       (LINEAR_BITS),
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_lane_blue (
        .i_clk       (i_clk),
        .i_byte      (i_req.in_blue),
        .i_factor    (cfg.factor_blue),
        .i_fill_we   (fill_we),
        .i_fill_addr (fill_addr),
        .i_fill_data (fill_data),
        .o_enc       (enc_blue)
    );

    // ---------------------------------------------------------------------
    // alpha: linear scale, truncate the 16 fraction bits, saturate at 255
    // ---------------------------------------------------------------------
    assign alpha_prod  = APROD_W'(r_p1.in_alpha) * APROD_W'(cfg.factor_alpha);
    assign alpha_shift = alpha_prod[APROD_W-1:FACTOR_FRAC];
    assign n_sa        = alpha_shift[BYTE_W] ? '1 : alpha_shift[BYTE_W-1:0];

    // payload stages follow the lane pipeline, no reset needed
    always_ff @(posedge i_clk) begin
        r_p1  <= i_req;
        r_p2  <= r_p1;
        r_p3  <= r_p2;
        r_sa2 <= n_sa;
        r_sa3 <= r_sa2;
    end

    // ---------------------------------------------------------------------
    // result select: pass the raw pixel when every factor in use is unity
    // ---------------------------------------------------------------------
    always_comb begin
        n_res.out_red   = r_p3.in_red;
        n_res.out_green = r_p3.in_green;
        n_res.out_blue  = r_p3.in_blue;
        n_res.out_alpha = r_p3.in_alpha;
        if (cfg.scale_mode == MODE_BASE) begin
            n_pass = (cfg.factor_red == UNIT_FACTOR) && (cfg.factor_green == UNIT_FACTOR) &&
                     (cfg.factor_blue == UNIT_FACTOR) && (cfg.factor_alpha == UNIT_FACTOR);
            if (!n_pass) begin
                n_res.out_red   = enc_red;
                n_res.out_green = enc_green;
                n_res.out_blue  = enc_blue;
                n_res.out_alpha = r_sa3;
            end
        end else begin
            // material mode: roughness in g, metallic in b, r and a untouched
            n_pass = (cfg.factor_green == UNIT_FACTOR) && (cfg.factor_blue == UNIT_FACTOR);
            if (!n_pass) begin
                n_res.out_green = enc_green;
                n_res.out_blue  = enc_blue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_pass <= n_pass;
    end

    // request valid shifts alongside the data, one stage per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[VLD_W-2:0], accept};
            r_done <= r_vld[VLD_W-1];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    `GCS_ASSERT_DELAY(a_result_latency, start && !busy, LATENCY, o_done)
    `GCS_ASSERT_SAME(a_no_spurious_result, o_done, $past(start && !busy, LATENCY))
    `GCS_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)
    `GCS_ASSERT_SAME(a_unit_passthrough, o_done && r_pass, o_res == $past(i_req, LATENCY))

endmodule
